// ----- rtl/core/fftp_pkg.sv -----
`default_nettype none
package fftp_pkg;

  localparam int CoordW = 32;
  localparam int DepthW = 31;
  localparam int ProdW = CoordW + DepthW;
  localparam int WideW = 67;
  localparam int InDataW = 96;
  localparam int OutDataW = 128;
  localparam int DivSteps = DepthW;
  localparam int DivCntW = $clog2(DivSteps + 1);

  localparam logic [DepthW-1:0] QMAX = {DepthW{1'b1}};
  localparam logic [DepthW-1:0] TAN_PI8 = DepthW'(27146);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SEED_MUL,
    OP_SEED,
    OP_BOUND,
    OP_MAG_MUL,
    OP_EXT_MUL,
    OP_DIV_START,
    OP_DIV_TAKE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic axis;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic seeded;
    logic grow;
    logic div_done;
  } status_t;

  function automatic logic [DepthW-1:0] sat31(input logic [WideW-1:0] v);
    logic [DepthW-1:0] r;
    r = (v > WideW'(QMAX)) ? QMAX : v[DepthW-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/fftp_div.sv -----
`default_nettype none
module fftp_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [fftp_pkg::ProdW-1:0]  dividend,
  input  wire logic [fftp_pkg::DepthW-1:0] divisor,
  output logic                             done,
  output logic [fftp_pkg::DepthW-1:0]      quotient
);

  logic                          busy;
  logic [fftp_pkg::DivCntW-1:0]  cnt;
  logic [fftp_pkg::DepthW-1:0]   rem;
  logic [fftp_pkg::DepthW-1:0]   lo;
  logic [fftp_pkg::DepthW-1:0]   dvs;
  logic                          sat;
  logic [fftp_pkg::DepthW:0]     trial;
  logic [fftp_pkg::DepthW:0]     diff;
  logic                          ge;

  assign trial = {rem, lo[fftp_pkg::DepthW-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= fftp_pkg::DivCntW'(fftp_pkg::DivSteps);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == fftp_pkg::DivCntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      sat <= dividend[fftp_pkg::ProdW-1:fftp_pkg::DepthW] >= {1'b0, divisor};
      rem <= dividend[fftp_pkg::ProdW-2:fftp_pkg::DepthW];
      lo  <= dividend[fftp_pkg::DepthW-1:0];
    end else if (busy) begin
      rem <= ge ? diff[fftp_pkg::DepthW-1:0] : trial[fftp_pkg::DepthW-1:0];
      lo  <= {lo[fftp_pkg::DepthW-2:0], ge};
    end
  end

  assign quotient = sat ? fftp_pkg::QMAX : lo;

endmodule
`default_nettype wire

// ----- rtl/core/fftp_dp.sv -----
`default_nettype none
module fftp_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire fftp_pkg::cmd_t                cmd,
  output fftp_pkg::status_t                  st,
  input  wire logic [fftp_pkg::InDataW-1:0]  in_data,
  output logic [fftp_pkg::OutDataW-1:0]      out_data
);

  logic                            seeded;
  logic [fftp_pkg::DepthW-1:0]     near_reg;
  logic [fftp_pkg::DepthW-1:0]     far_reg;
  logic [fftp_pkg::DepthW-1:0]     width_reg;
  logic [fftp_pkg::DepthW-1:0]     height_reg;
  logic [fftp_pkg::CoordW-1:0]     ax;
  logic [fftp_pkg::CoordW-1:0]     ay;
  logic [fftp_pkg::DepthW-1:0]     z;
  logic [fftp_pkg::ProdW-1:0]      prod_a;
  logic [fftp_pkg::ProdW-1:0]      prod_b;

  logic [fftp_pkg::CoordW-1:0]     in_x;
  logic [fftp_pkg::CoordW-1:0]     in_y;
  logic [fftp_pkg::DepthW-1:0]     in_z;
  logic [fftp_pkg::CoordW-1:0]     mag_sel;
  logic [fftp_pkg::DepthW-1:0]     ext_sel;
  logic [fftp_pkg::CoordW-1:0]     mul_a;
  logic [fftp_pkg::DepthW-1:0]     mul_b;
  logic [fftp_pkg::ProdW-1:0]      prod;
  logic [fftp_pkg::DepthW-1:0]     seed_ext_all;
  logic [fftp_pkg::DepthW-1:0]     seed_w;
  logic [fftp_pkg::DepthW-1:0]     seed_h;
  logic [fftp_pkg::DepthW-1:0]     seed_far;
  logic                            div_done;
  logic [fftp_pkg::DepthW-1:0]     quotient;

  function automatic logic [fftp_pkg::DepthW-1:0] seed_ext(
    input logic [fftp_pkg::CoordW-1:0] mag,
    input logic [fftp_pkg::ProdW-1:0]  thr,
    input logic [fftp_pkg::DepthW-1:0] base
  );
    logic [fftp_pkg::WideW-1:0] m;
    logic [fftp_pkg::DepthW-1:0] r;
    m = fftp_pkg::WideW'(mag);
    if ((m << 17) > fftp_pkg::WideW'(thr)) begin
      r = fftp_pkg::sat31((m << 3) + (m << 1));
    end else begin
      r = base;
    end
    return r;
  endfunction

  assign in_x = in_data[fftp_pkg::CoordW-1:0];
  assign in_y = in_data[2*fftp_pkg::CoordW-1:fftp_pkg::CoordW];
  assign in_z = in_data[2*fftp_pkg::CoordW+fftp_pkg::DepthW-1:2*fftp_pkg::CoordW];

  assign mag_sel = cmd.axis ? ay : ax;
  assign ext_sel = cmd.axis ? height_reg : width_reg;

  always_comb begin
    case (cmd.op)
      fftp_pkg::OP_SEED_MUL: begin
        mul_a = fftp_pkg::CoordW'(z);
        mul_b = fftp_pkg::TAN_PI8;
      end
      fftp_pkg::OP_MAG_MUL: begin
        mul_a = mag_sel;
        mul_b = far_reg;
      end
      fftp_pkg::OP_EXT_MUL: begin
        mul_a = fftp_pkg::CoordW'(ext_sel);
        mul_b = z;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = fftp_pkg::ProdW'(mul_a) * fftp_pkg::ProdW'(mul_b);

  assign seed_ext_all = fftp_pkg::sat31(
    ((fftp_pkg::WideW'(prod_a) << 3) + (fftp_pkg::WideW'(prod_a) << 1)) >> 16);
  assign seed_w   = seed_ext(ax, prod_a, seed_ext_all);
  assign seed_h   = seed_ext(ay, prod_a, seed_ext_all);
  assign seed_far = fftp_pkg::sat31((fftp_pkg::WideW'(z) << 3) + (fftp_pkg::WideW'(z) << 1));

  fftp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == fftp_pkg::OP_DIV_START),
    .dividend (prod_a),
    .divisor  (z),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.op == fftp_pkg::OP_LOAD) begin
      ax <= in_x[fftp_pkg::CoordW-1] ? (~in_x + 1'b1) : in_x;
      ay <= in_y[fftp_pkg::CoordW-1] ? (~in_y + 1'b1) : in_y;
      z  <= (in_z == '0) ? fftp_pkg::DepthW'(1) : in_z;
    end
    if (cmd.op == fftp_pkg::OP_SEED_MUL || cmd.op == fftp_pkg::OP_MAG_MUL) begin
      prod_a <= prod;
    end
    if (cmd.op == fftp_pkg::OP_EXT_MUL) begin
      prod_b <= prod;
    end
    if (cmd.out_load) begin
      out_data <= {4'b0, height_reg, width_reg, far_reg, near_reg};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded     <= 1'b0;
      near_reg   <= '0;
      far_reg    <= '0;
      width_reg  <= '0;
      height_reg <= '0;
    end else begin
      case (cmd.op)
        fftp_pkg::OP_SEED: begin
          seeded     <= 1'b1;
          near_reg   <= z >> 1;
          far_reg    <= seed_far;
          width_reg  <= seed_w;
          height_reg <= seed_h;
        end
        fftp_pkg::OP_BOUND: begin
          if (z < near_reg) begin
            near_reg <= z;
          end
          if (z > far_reg) begin
            far_reg <= z;
          end
        end
        fftp_pkg::OP_DIV_TAKE: begin
          if (cmd.axis) begin
            height_reg <= quotient;
          end else begin
            width_reg <= quotient;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign st.seeded   = seeded;
  assign st.grow     = prod_a > prod_b;
  assign st.div_done = div_done;

endmodule
`default_nettype wire

// ----- rtl/core/fftp_ctrl.sv -----
`default_nettype none
module fftp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire fftp_pkg::status_t  st,
  output fftp_pkg::cmd_t          cmd
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_SEED_MUL = 9'b000000010,
    ST_SEED     = 9'b000000100,
    ST_BOUND    = 9'b000001000,
    ST_MAG_MUL  = 9'b000010000,
    ST_EXT_MUL  = 9'b000100000,
    ST_TEST     = 9'b001000000,
    ST_DIV      = 9'b010000000,
    ST_DONE     = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   axis;
  logic   axis_next;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    axis_next    = axis;
    cmd.op       = fftp_pkg::OP_NONE;
    cmd.axis     = axis;
    cmd.out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = fftp_pkg::OP_LOAD;
          state_next = st.seeded ? ST_BOUND : ST_SEED_MUL;
        end
      end
      ST_SEED_MUL: begin
        cmd.op     = fftp_pkg::OP_SEED_MUL;
        state_next = ST_SEED;
      end
      ST_SEED: begin
        cmd.op     = fftp_pkg::OP_SEED;
        state_next = ST_DONE;
      end
      ST_BOUND: begin
        cmd.op     = fftp_pkg::OP_BOUND;
        axis_next  = 1'b0;
        state_next = ST_MAG_MUL;
      end
      ST_MAG_MUL: begin
        cmd.op     = fftp_pkg::OP_MAG_MUL;
        state_next = ST_EXT_MUL;
      end
      ST_EXT_MUL: begin
        cmd.op     = fftp_pkg::OP_EXT_MUL;
        state_next = ST_TEST;
      end
      ST_TEST: begin
        if (st.grow) begin
          cmd.op     = fftp_pkg::OP_DIV_START;
          state_next = ST_DIV;
        end else if (!axis) begin
          axis_next  = 1'b1;
          state_next = ST_MAG_MUL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV: begin
        if (st.div_done) begin
          cmd.op = fftp_pkg::OP_DIV_TAKE;
          if (!axis) begin
            axis_next  = 1'b1;
            state_next = ST_MAG_MUL;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      axis      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_div_only_on_grow: assert property (@(posedge clk) disable iff (rst)
    cmd.op == fftp_pkg::OP_DIV_START |-> st.grow)
    else $error("division started without widening");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    st.div_done |-> state == ST_DIV)
    else $error("divider finished outside the wait state");

  a_seed_once: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEED_MUL |-> !st.seeded)
    else $error("seed path taken after seeding");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside the done state");

endmodule
`default_nettype wire

// ----- rtl/core/frustum_fit_to_points.sv -----
`default_nettype none
// Fits a view frustum around a stream of 3D points (Q16.16).
// Input channel s_axis: one point per transaction, tdata = {z, y, x}.
// Output channel m_axis: one result per point with the current near, far,
// half width and half height, all Q16.16 and saturated at the maximum.
// The first point after reset seeds the frustum; later points grow it.
// The first point passes the seed multiply and seed step; a later point
// the bound update, then for width and then height a magnitude multiply,
// an extent multiply, a test and, if that extent widens, a division by
// the 31-step restoring divider shared between width and height. One
// point is worked on at a time; s_axis_tready is high only while idle.
// The finished result sits in an output register, so a stalled receiver
// holds m_axis_tvalid and tdata while the next point is taken and worked;
// that next point waits at the end only if the register is still full.
// Reset (rst, synchronous) clears the frustum to zero and forgets the seed.
module frustum_fit_to_points (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[94:64], zero[95]
  input  wire logic [fftp_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // near_depth[30:0], far_depth[61:31], half_width[92:62],
  // half_height[123:93], zero[127:124]
  output logic [fftp_pkg::OutDataW-1:0]      m_axis_tdata
);

  fftp_pkg::cmd_t    cmd;
  fftp_pkg::status_t st;

  fftp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .st        (st),
    .cmd       (cmd)
  );

  fftp_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .in_data  (s_axis_tdata),
    .out_data (m_axis_tdata)
  );

endmodule
`default_nettype wire
